// ===== rtl/core/sef_pkg.sv =====
// ----------------------------------------------------------------------------
// sef_pkg
// Shared constants, codes and types for the stroke extremum finder.
// ----------------------------------------------------------------------------
package sef_pkg;

    // Element table size per trace and history depth (power of two)
    localparam int MAX_ELEMENTS  = 256;
    localparam int HISTORY_DEPTH = 1024;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
    localparam int ELEM_CW       = $clog2(MAX_ELEMENTS + 1);

    localparam logic [14:0] HYST_RESET = 15'd16;

    // Record kinds; K_EMPTY is internal only (nothing added yet)
    typedef enum logic [2:0] {
        K_BEG   = 3'd0,
        K_MIN   = 3'd1,
        K_MAX   = 3'd2,
        K_END   = 3'd3,
        K_EMPTY = 3'd4
    } elem_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROC,
        ST_SWING,
        ST_SEARCH,
        ST_EMIT,
        ST_FIN
    } core_state_t;

    typedef enum logic [1:0] {
        SR_IDLE,
        SR_READ,
        SR_CMP
    } search_state_t;

    typedef struct packed {
        logic [14:0]        from_idx;
        logic [14:0]        lo_idx;
        logic signed [15:0] extreme;
        logic               is_max;
    } search_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [15:0] begin_idx;
    } search_rsp_t;

endpackage

// ===== rtl/core/sef_search.sv =====
// ----------------------------------------------------------------------------
// sef_search
// Sample history memory and backward walk for an extremum's begin index.
// ----------------------------------------------------------------------------
module sef_search (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [14:0]                     hyst,
    input  logic                            wr_en,
    input  logic [sef_pkg::HIST_AW-1:0]     wr_addr,
    input  logic signed [15:0]              wr_data,
    input  logic                            start,
    input  sef_pkg::search_req_t            req,
    output sef_pkg::search_rsp_t            rsp
);

    sef_pkg::search_state_t state_reg, state_next;

    logic [14:0]        j_reg, j_next;
    logic [14:0]        lo_reg, lo_next;
    logic signed [15:0] ext_reg, ext_next;
    logic               is_max_reg, is_max_next;
    logic signed [15:0] rd_data_reg;

    logic signed [15:0] hist_mem [sef_pkg::HISTORY_DEPTH];

    logic               below_lo;
    logic               at_lo;
    logic               hit;
    logic               rd_en;
    logic signed [16:0] diff;
    logic signed [15:0] lo_minus_one;

    assign below_lo     = j_reg < lo_reg;
    assign at_lo        = j_reg == lo_reg;
    assign lo_minus_one = $signed({1'b0, lo_reg}) - 16'sd1;

    // distance from the extremum towards the opposite direction
    always_comb
    begin
        if (is_max_reg)
        begin
            diff = $signed({ext_reg[15], ext_reg}) - $signed({rd_data_reg[15], rd_data_reg});
        end
        else
        begin
            diff = $signed({rd_data_reg[15], rd_data_reg}) - $signed({ext_reg[15], ext_reg});
        end
        hit = diff > $signed({2'b00, hyst});
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sef_pkg::SR_IDLE:
            begin
                if (start)
                begin
                    state_next = sef_pkg::SR_READ;
                end
            end
            sef_pkg::SR_READ:
            begin
                state_next = below_lo ? sef_pkg::SR_IDLE : sef_pkg::SR_CMP;
            end
            sef_pkg::SR_CMP:
            begin
                state_next = (hit || at_lo) ? sef_pkg::SR_IDLE : sef_pkg::SR_READ;
            end
            default:
            begin
                state_next = sef_pkg::SR_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp.busy      = state_reg != sef_pkg::SR_IDLE;
        rsp.done      = 1'b0;
        rsp.begin_idx = lo_minus_one;
        rd_en         = 1'b0;
        j_next        = j_reg;
        lo_next       = lo_reg;
        ext_next      = ext_reg;
        is_max_next   = is_max_reg;
        unique case (state_reg)
            sef_pkg::SR_IDLE:
            begin
                if (start)
                begin
                    j_next      = req.from_idx;
                    lo_next     = req.lo_idx;
                    ext_next    = req.extreme;
                    is_max_next = req.is_max;
                end
            end
            sef_pkg::SR_READ:
            begin
                rsp.done = below_lo;
                rd_en    = !below_lo;
            end
            sef_pkg::SR_CMP:
            begin
                if (hit)
                begin
                    rsp.done      = 1'b1;
                    rsp.begin_idx = $signed({1'b0, j_reg});
                end
                else if (at_lo)
                begin
                    rsp.done = 1'b1;
                end
                else
                begin
                    j_next = j_reg - 15'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sef_pkg::SR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg      <= j_next;
        lo_reg     <= lo_next;
        ext_reg    <= ext_next;
        is_max_reg <= is_max_next;
    end

    // single port memory: one write or one read per cycle in practice
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= hist_mem[j_reg[sef_pkg::HIST_AW-1:0]];
        end
    end

endmodule

// ===== rtl/core/stroke_extremum_finder_core.sv =====
// ----------------------------------------------------------------------------
// stroke_extremum_finder_core
// Pen sample stream in, stroke begin / min / max / end records out.
//
//  channel | direction | beat contents
//  --------+-----------+--------------------------------------------------
//  s_*     | in        | tdata: sample_y; tuser: pen_up, new_trace
//  m_*     | out       | tdata: begin/point/end index; tuser: kind; tlast
//  cfg_*   | in        | hysteresis depth, written when wr_en is high
//
// A history search reads and compares each entry walked, and ends at once if
// the extremum lies below the search window. A point sample that declares
// a stroke's first extremum emits it directly; a later one waits for the
// search first. A break gives or drops each record, after the search for a
// pending extremum. A sample after index exhaustion is taken and ignored.
// Reset clears control state; the history memory is not cleared.
// s_tready is high only between beats; the sequencer holds in its emit step
// while the output register is full, m_tready is low and the table has room.
// ----------------------------------------------------------------------------
module stroke_extremum_finder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [14:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [15:0] sample_y
    input  logic [1:0]  s_tuser,     // [0] pen_up, [1] new_trace
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,     // [15:0] begin_index, [30:16] point_index,
                                     // [45:31] end_index, [47:46] zero
    output logic [1:0]  m_tuser,     // [1:0] kind
    output logic        m_tlast
);

    localparam logic [sef_pkg::ELEM_CW-1:0] ELEM_LIMIT =
        sef_pkg::ELEM_CW'(sef_pkg::MAX_ELEMENTS);
    localparam logic [sef_pkg::ELEM_CW-1:0] ELEM_LAST =
        sef_pkg::ELEM_CW'(sef_pkg::MAX_ELEMENTS - 1);
    localparam logic [15:0] DEPTH_W = 16'(sef_pkg::HISTORY_DEPTH);

    sef_pkg::core_state_t state_reg, state_next;
    sef_pkg::elem_kind_t  last_kind_reg, last_kind_next;
    sef_pkg::elem_kind_t  rec_kind_reg, rec_kind_next;

    logic [14:0]                 hyst_reg, hyst_next;
    logic [14:0]                 sample_count_reg, sample_count_next;
    logic                        exhausted_reg, exhausted_next;
    logic [sef_pkg::ELEM_CW-1:0] elem_count_reg, elem_count_next;
    logic                        prev_break_reg, prev_break_next;
    logic signed [15:0]          run_max_reg, run_max_next;
    logic signed [15:0]          run_min_reg, run_min_next;
    logic [14:0]                 max_pos_reg, max_pos_next;
    logic [14:0]                 min_pos_reg, min_pos_next;
    logic [14:0]                 stroke_start_reg, stroke_start_next;
    logic signed [15:0]          y_reg, y_next;
    logic                        up_reg, up_next;
    logic signed [15:0]          rec_begin_reg, rec_begin_next;
    logic [14:0]                 rec_point_reg, rec_point_next;
    logic [14:0]                 rec_end_reg, rec_end_next;
    logic                        then_end_reg, then_end_next;
    logic                        restart_reg, restart_next;

    logic                        m_valid_reg, m_valid_next;
    logic [1:0]                  m_kind_reg, m_kind_next;
    logic signed [15:0]          m_begin_reg, m_begin_next;
    logic [14:0]                 m_point_reg, m_point_next;
    logic [14:0]                 m_end_reg, m_end_next;
    logic                        m_last_reg, m_last_next;

    logic [14:0]                 idx;
    logic [14:0]                 idx_dec;
    logic                        end_cond;
    logic                        swing;
    logic                        opp_pending;
    logic                        table_full;
    logic                        out_free;
    logic [15:0]                 win_top;
    logic [15:0]                 win_lo;
    logic                        win_ok;
    logic signed [16:0]          span;

    logic                        in_take;
    logic                        search_start;
    logic                        hist_wr_en;
    logic                        emit_load;
    logic                        emit_done;

    sef_pkg::search_req_t        search_req;
    sef_pkg::search_rsp_t        search_rsp;

    assign idx         = sample_count_reg;
    assign idx_dec     = sample_count_reg - 15'd1;
    assign end_cond    = (idx != 15'd0) && !prev_break_reg;
    assign opp_pending = (last_kind_reg == sef_pkg::K_MIN) || (last_kind_reg == sef_pkg::K_MAX);
    assign table_full  = elem_count_reg >= ELEM_LIMIT;
    assign out_free    = !m_valid_reg || m_tready;
    assign span        = $signed({run_max_reg[15], run_max_reg})
                       - $signed({run_min_reg[15], run_min_reg});
    assign swing       = span > $signed({2'b00, hyst_reg});

    // only intact history of the current stroke is searched
    assign win_top = {1'b0, idx} + 16'd1;
    assign win_ok  = win_top >= DEPTH_W;
    assign win_lo  = win_top - DEPTH_W;

    always_comb
    begin
        search_req.is_max = last_kind_reg == sef_pkg::K_MIN;
        if (last_kind_reg == sef_pkg::K_MIN)
        begin
            search_req.from_idx = max_pos_reg;
            search_req.extreme  = run_max_reg;
        end
        else
        begin
            search_req.from_idx = min_pos_reg;
            search_req.extreme  = run_min_reg;
        end
        if (win_ok && (win_lo[14:0] > stroke_start_reg))
        begin
            search_req.lo_idx = win_lo[14:0];
        end
        else
        begin
            search_req.lo_idx = stroke_start_reg;
        end
    end

    sef_search u_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .hyst    (hyst_reg),
        .wr_en   (hist_wr_en),
        .wr_addr (idx[sef_pkg::HIST_AW-1:0]),
        .wr_data (y_reg),
        .start   (search_start),
        .req     (search_req),
        .rsp     (search_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sef_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = sef_pkg::ST_PROC;
                end
            end
            sef_pkg::ST_PROC:
            begin
                if (exhausted_reg)
                begin
                    state_next = sef_pkg::ST_IDLE;
                end
                else if (up_reg)
                begin
                    if (opp_pending)
                    begin
                        state_next = sef_pkg::ST_SEARCH;
                    end
                    else if (end_cond)
                    begin
                        state_next = sef_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = sef_pkg::ST_FIN;
                    end
                end
                else if (prev_break_reg)
                begin
                    state_next = sef_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = sef_pkg::ST_SWING;
                end
            end
            sef_pkg::ST_SWING:
            begin
                if (swing && (last_kind_reg == sef_pkg::K_BEG))
                begin
                    state_next = sef_pkg::ST_EMIT;
                end
                else if (swing && opp_pending)
                begin
                    state_next = sef_pkg::ST_SEARCH;
                end
                else
                begin
                    state_next = sef_pkg::ST_FIN;
                end
            end
            sef_pkg::ST_SEARCH:
            begin
                if (search_rsp.done)
                begin
                    state_next = sef_pkg::ST_EMIT;
                end
            end
            sef_pkg::ST_EMIT:
            begin
                if (emit_done)
                begin
                    state_next = then_end_reg ? sef_pkg::ST_EMIT : sef_pkg::ST_FIN;
                end
            end
            sef_pkg::ST_FIN:
            begin
                state_next = sef_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sef_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready     = 1'b0;
        search_start = 1'b0;
        hist_wr_en   = 1'b0;
        emit_load    = 1'b0;
        emit_done    = 1'b0;
        unique case (state_reg)
            sef_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            sef_pkg::ST_PROC:
            begin
                search_start = !exhausted_reg && up_reg && opp_pending;
                hist_wr_en   = !exhausted_reg && !up_reg;
            end
            sef_pkg::ST_SWING:
            begin
                search_start = swing && opp_pending;
            end
            sef_pkg::ST_EMIT:
            begin
                emit_load = !table_full && out_free;
                emit_done = table_full || out_free;
            end
            default:
            begin
            end
        endcase
    end

    assign in_take = s_tvalid && s_tready;

    // datapath
    always_comb
    begin
        hyst_next         = cfg_wr_en ? cfg_wr_data : hyst_reg;
        sample_count_next = sample_count_reg;
        exhausted_next    = exhausted_reg;
        elem_count_next   = elem_count_reg;
        last_kind_next    = last_kind_reg;
        prev_break_next   = prev_break_reg;
        run_max_next      = run_max_reg;
        run_min_next      = run_min_reg;
        max_pos_next      = max_pos_reg;
        min_pos_next      = min_pos_reg;
        stroke_start_next = stroke_start_reg;
        y_next            = y_reg;
        up_next           = up_reg;
        rec_kind_next     = rec_kind_reg;
        rec_begin_next    = rec_begin_reg;
        rec_point_next    = rec_point_reg;
        rec_end_next      = rec_end_reg;
        then_end_next     = then_end_reg;
        restart_next      = restart_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        m_kind_next       = m_kind_reg;
        m_begin_next      = m_begin_reg;
        m_point_next      = m_point_reg;
        m_end_next        = m_end_reg;
        m_last_next       = m_last_reg;

        unique case (state_reg)
            sef_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    y_next  = $signed(s_tdata);
                    up_next = s_tuser[0];
                    if (s_tuser[1])
                    begin
                        sample_count_next = '0;
                        exhausted_next    = 1'b0;
                        elem_count_next   = '0;
                        last_kind_next    = sef_pkg::K_EMPTY;
                        prev_break_next   = 1'b1;
                    end
                end
            end
            sef_pkg::ST_PROC:
            begin
                restart_next  = 1'b0;
                then_end_next = 1'b0;
                if (up_reg)
                begin
                    rec_end_next = idx_dec;
                    if (last_kind_reg == sef_pkg::K_MIN)
                    begin
                        rec_kind_next  = sef_pkg::K_MAX;
                        rec_point_next = max_pos_reg;
                        then_end_next  = end_cond;
                    end
                    else if (last_kind_reg == sef_pkg::K_MAX)
                    begin
                        rec_kind_next  = sef_pkg::K_MIN;
                        rec_point_next = min_pos_reg;
                        then_end_next  = end_cond;
                    end
                    else
                    begin
                        rec_kind_next  = sef_pkg::K_END;
                        rec_begin_next = $signed({1'b0, idx_dec});
                        rec_point_next = idx_dec;
                    end
                end
                else if (prev_break_reg)
                begin
                    rec_kind_next     = sef_pkg::K_BEG;
                    rec_begin_next    = $signed({1'b0, idx});
                    rec_point_next    = idx;
                    rec_end_next      = idx;
                    stroke_start_next = idx;
                    run_max_next      = y_reg;
                    run_min_next      = y_reg;
                    max_pos_next      = idx;
                    min_pos_next      = idx;
                end
                else
                begin
                    case (last_kind_reg)
                        sef_pkg::K_BEG:
                        begin
                            if (y_reg < run_min_reg)
                            begin
                                run_min_next = y_reg;
                                min_pos_next = idx;
                            end
                            if (y_reg > run_max_reg)
                            begin
                                run_max_next = y_reg;
                                max_pos_next = idx;
                            end
                        end
                        // a new high after a minimum restarts the minimum too
                        sef_pkg::K_MIN:
                        begin
                            if (y_reg < run_min_reg)
                            begin
                                run_min_next = y_reg;
                                min_pos_next = idx;
                            end
                            else if (y_reg > run_max_reg)
                            begin
                                run_max_next = y_reg;
                                max_pos_next = idx;
                                run_min_next = y_reg;
                                min_pos_next = idx;
                            end
                        end
                        sef_pkg::K_MAX:
                        begin
                            if (y_reg < run_min_reg)
                            begin
                                run_min_next = y_reg;
                                min_pos_next = idx;
                                run_max_next = y_reg;
                                max_pos_next = idx;
                            end
                            else if (y_reg > run_max_reg)
                            begin
                                run_max_next = y_reg;
                                max_pos_next = idx;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            sef_pkg::ST_SWING:
            begin
                restart_next = swing;
                rec_end_next = idx;
                case (last_kind_reg)
                    sef_pkg::K_BEG:
                    begin
                        rec_begin_next = $signed({1'b0, stroke_start_reg});
                        if (max_pos_reg > min_pos_reg)
                        begin
                            rec_kind_next  = sef_pkg::K_MIN;
                            rec_point_next = min_pos_reg;
                        end
                        else
                        begin
                            rec_kind_next  = sef_pkg::K_MAX;
                            rec_point_next = max_pos_reg;
                        end
                    end
                    sef_pkg::K_MIN:
                    begin
                        rec_kind_next  = sef_pkg::K_MAX;
                        rec_point_next = max_pos_reg;
                    end
                    sef_pkg::K_MAX:
                    begin
                        rec_kind_next  = sef_pkg::K_MIN;
                        rec_point_next = min_pos_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            sef_pkg::ST_SEARCH:
            begin
                if (search_rsp.done)
                begin
                    rec_begin_next = search_rsp.begin_idx;
                end
            end
            sef_pkg::ST_EMIT:
            begin
                if (emit_load)
                begin
                    m_valid_next    = 1'b1;
                    m_kind_next     = rec_kind_reg[1:0];
                    m_begin_next    = rec_begin_reg;
                    m_point_next    = rec_point_reg;
                    m_end_next      = rec_end_reg;
                    // a stroke end follows only if the table still has room
                    m_last_next     = !(then_end_reg && (elem_count_reg < ELEM_LAST));
                    elem_count_next = elem_count_reg + 1'b1;
                    last_kind_next  = rec_kind_reg;
                end
                else if (table_full)
                begin
                    last_kind_next = sef_pkg::K_EMPTY;
                end
                if (emit_done && then_end_reg)
                begin
                    rec_kind_next  = sef_pkg::K_END;
                    rec_begin_next = $signed({1'b0, idx_dec});
                    rec_point_next = idx_dec;
                    rec_end_next   = idx_dec;
                    then_end_next  = 1'b0;
                end
            end
            sef_pkg::ST_FIN:
            begin
                sample_count_next = sample_count_reg + 15'd1;
                exhausted_next    = &sample_count_reg;
                prev_break_next   = up_reg;
                if (restart_reg)
                begin
                    run_max_next = y_reg;
                    run_min_next = y_reg;
                    max_pos_next = idx;
                    min_pos_next = idx;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sef_pkg::ST_IDLE;
            hyst_reg         <= sef_pkg::HYST_RESET;
            sample_count_reg <= '0;
            exhausted_reg    <= 1'b0;
            elem_count_reg   <= '0;
            last_kind_reg    <= sef_pkg::K_EMPTY;
            prev_break_reg   <= 1'b1;
            run_max_reg      <= '0;
            run_min_reg      <= '0;
            max_pos_reg      <= '0;
            min_pos_reg      <= '0;
            stroke_start_reg <= '0;
            then_end_reg     <= 1'b0;
            restart_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            hyst_reg         <= hyst_next;
            sample_count_reg <= sample_count_next;
            exhausted_reg    <= exhausted_next;
            elem_count_reg   <= elem_count_next;
            last_kind_reg    <= last_kind_next;
            prev_break_reg   <= prev_break_next;
            run_max_reg      <= run_max_next;
            run_min_reg      <= run_min_next;
            max_pos_reg      <= max_pos_next;
            min_pos_reg      <= min_pos_next;
            stroke_start_reg <= stroke_start_next;
            then_end_reg     <= then_end_next;
            restart_reg      <= restart_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg         <= y_next;
        up_reg        <= up_next;
        rec_kind_reg  <= rec_kind_next;
        rec_begin_reg <= rec_begin_next;
        rec_point_reg <= rec_point_next;
        rec_end_reg   <= rec_end_next;
        m_kind_reg    <= m_kind_next;
        m_begin_reg   <= m_begin_next;
        m_point_reg   <= m_point_next;
        m_end_reg     <= m_end_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_end_reg, m_point_reg, m_begin_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    // element table never overfills
    a_elem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        elem_count_reg <= ELEM_LIMIT)
        else $error("element count beyond table size");

    // search is only started while the walker is free
    a_search_free: assert property (@(posedge clk) disable iff (!rst_n)
        search_start |-> !search_rsp.busy)
        else $error("search started while busy");

    // a non-final beat can only be an extremum ahead of a stroke end
    a_nonlast_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_load && then_end_reg && (elem_count_reg < ELEM_LAST))
        |-> (rec_kind_reg == sef_pkg::K_MIN || rec_kind_reg == sef_pkg::K_MAX))
        else $error("non-final record of unexpected kind");

    // output register is never overwritten while stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit_load |-> (!m_valid_reg || m_tready))
        else $error("output beat overwritten");

endmodule

// ===== dv/stroke_extremum_finder_core_tb.sv =====
// ----------------------------------------------------------------------------
// stroke_extremum_finder_core_tb
// Streams pen samples into the extremum finder and checks every record beat
// against an in-bench predictor of the stroke and extremum tracking. The run
// covers directed corners, element table overflow and random strokes under
// several hysteresis depths and handshake idling mixes.
// ----------------------------------------------------------------------------
module stroke_extremum_finder_core_tb;

    localparam int CYCLE_LIMIT   = 10_000_000;
    // longest possible search walk plus the sequencer's own steps
    localparam int SETTLE_CYCLES = 2100;
    localparam int INDEX_SPAN    = 32768;
    localparam int MAX_PRINTS    = 100;

    typedef struct {
        logic [1:0]         kind;
        logic signed [15:0] begin_idx;
        logic [14:0]        point_idx;
        logic [14:0]        end_idx;
        logic               last;
    } elem_record_t;

    class extremum_scoreboard;
        int                  depth;
        int                  n_samples;
        bit                  exhausted;
        int                  n_elems;
        sef_pkg::elem_kind_t last_kind;
        int                  run_max;
        int                  run_min;
        int                  max_pos;
        int                  min_pos;
        int                  stroke_start;
        bit                  prev_break;
        int                  y_history [sef_pkg::HISTORY_DEPTH];
        elem_record_t        step_records [$];
        elem_record_t        expected_records [$];
        int                  errors;

        function new();
            depth        = int'(sef_pkg::HYST_RESET);
            n_samples    = 0;
            exhausted    = 0;
            n_elems      = 0;
            last_kind    = sef_pkg::K_EMPTY;
            run_max      = 0;
            run_min      = 0;
            max_pos      = 0;
            min_pos      = 0;
            stroke_start = 0;
            prev_break   = 1;
            errors       = 0;
        endfunction

        function void set_depth(int d);
            depth = d;
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS)
                $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        // Walk back from the extremum for the first sample further away than
        // the depth; bounded to the stroke and to intact history.
        function int seek_begin(int from, int extreme, bit is_max, int cur);
            int lo;
            int j;
            int d;
            lo = stroke_start;
            if (cur + 1 - sef_pkg::HISTORY_DEPTH > lo)
                lo = cur + 1 - sef_pkg::HISTORY_DEPTH;
            for (j = from; j >= lo; j--)
            begin
                d = is_max ? extreme - y_history[j % sef_pkg::HISTORY_DEPTH]
                           : y_history[j % sef_pkg::HISTORY_DEPTH] - extreme;
                if (d > depth)
                    return j;
            end
            return lo - 1;
        endfunction

        function sef_pkg::elem_kind_t add_record(sef_pkg::elem_kind_t k, int b, int p,
                                                 int e);
            elem_record_t r;
            if (n_elems >= sef_pkg::MAX_ELEMENTS)
                return sef_pkg::K_EMPTY;
            r.kind      = k[1:0];
            r.begin_idx = 16'(b);
            r.point_idx = 15'(p);
            r.end_idx   = 15'(e);
            r.last      = 1'b0;
            step_records.push_back(r);
            n_elems++;
            return k;
        endfunction

        function void note_sample(logic signed [15:0] y, bit up, bit nt);
            int i;
            int v;
            int b;
            if (nt)
            begin
                n_samples  = 0;
                exhausted  = 0;
                n_elems    = 0;
                last_kind  = sef_pkg::K_EMPTY;
                prev_break = 1;
            end
            if (exhausted)
                return;
            i = n_samples;
            v = y;
            step_records.delete();
            if (up)
            begin
                if (last_kind == sef_pkg::K_MIN)
                begin
                    b = seek_begin(max_pos, run_max, 1'b1, i);
                    last_kind = add_record(sef_pkg::K_MAX, b, max_pos, i - 1);
                end
                else if (last_kind == sef_pkg::K_MAX)
                begin
                    b = seek_begin(min_pos, run_min, 1'b0, i);
                    last_kind = add_record(sef_pkg::K_MIN, b, min_pos, i - 1);
                end
                if (i > 0 && !prev_break)
                    last_kind = add_record(sef_pkg::K_END, i - 1, i - 1, i - 1);
                prev_break = 1;
            end
            else
            begin
                y_history[i % sef_pkg::HISTORY_DEPTH] = v;
                if (prev_break)
                begin
                    last_kind    = add_record(sef_pkg::K_BEG, i, i, i);
                    stroke_start = i;
                    run_max      = v;
                    run_min      = v;
                    max_pos      = i;
                    min_pos      = i;
                end
                else
                begin
                    case (last_kind)
                        sef_pkg::K_BEG:
                        begin
                            if (v < run_min) begin run_min = v; min_pos = i; end
                            if (v > run_max) begin run_max = v; max_pos = i; end
                        end
                        sef_pkg::K_MIN:
                        begin
                            if (v < run_min) begin run_min = v; min_pos = i; end
                            if (v > run_max)
                            begin
                                run_max = v; max_pos = i;
                                run_min = v; min_pos = i;
                            end
                        end
                        sef_pkg::K_MAX:
                        begin
                            if (v < run_min)
                            begin
                                run_min = v; min_pos = i;
                                run_max = v; max_pos = i;
                            end
                            if (v > run_max) begin run_max = v; max_pos = i; end
                        end
                        default: ;
                    endcase
                    if (run_max - run_min > depth)
                    begin
                        case (last_kind)
                            sef_pkg::K_BEG:
                            begin
                                if (max_pos > min_pos)
                                    last_kind = add_record(sef_pkg::K_MIN, stroke_start,
                                                           min_pos, i);
                                else
                                    last_kind = add_record(sef_pkg::K_MAX, stroke_start,
                                                           max_pos, i);
                            end
                            sef_pkg::K_MIN:
                            begin
                                b = seek_begin(max_pos, run_max, 1'b1, i);
                                last_kind = add_record(sef_pkg::K_MAX, b, max_pos, i);
                            end
                            sef_pkg::K_MAX:
                            begin
                                b = seek_begin(min_pos, run_min, 1'b0, i);
                                last_kind = add_record(sef_pkg::K_MIN, b, min_pos, i);
                            end
                            default: ;
                        endcase
                        run_min = v;
                        run_max = v;
                        min_pos = i;
                        max_pos = i;
                    end
                end
                prev_break = 0;
            end
            n_samples++;
            if (n_samples >= INDEX_SPAN)
                exhausted = 1;
            if (step_records.size() > 0)
                step_records[step_records.size() - 1].last = 1'b1;
            foreach (step_records[k])
                expected_records.push_back(step_records[k]);
        endfunction

        task check_record(elem_record_t got);
            elem_record_t want;
            if (expected_records.size() == 0)
            begin
                report($sformatf("record kind %0d point %0d with none expected",
                                 got.kind, got.point_idx));
                return;
            end
            want = expected_records.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind: got %0d, expected %0d", got.kind, want.kind));
            if (got.begin_idx !== want.begin_idx)
                report($sformatf("begin_index: got %0d, expected %0d",
                                 got.begin_idx, want.begin_idx));
            if (got.point_idx !== want.point_idx)
                report($sformatf("point_index: got %0d, expected %0d",
                                 got.point_idx, want.point_idx));
            if (got.end_idx !== want.end_idx)
                report($sformatf("end_index: got %0d, expected %0d",
                                 got.end_idx, want.end_idx));
            if (got.last !== want.last)
                report($sformatf("tlast: got %0b, expected %0b", got.last, want.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [14:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;     // [15:0] sample_y
    logic [1:0]  s_tuser;     // [0] pen_up, [1] new_trace
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;     // [15:0] begin_index, [30:16] point_index, [45:31] end_index
    logic [1:0]  m_tuser;     // [1:0] kind
    logic        m_tlast;

    extremum_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    int cycle_count = 0;

    stroke_extremum_finder_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("stroke_extremum_finder_core_tb failed");
            $finish;
        end
    end

    // record side: check the beat taken at this edge, then pick the next ready
    always @(posedge clk)
    begin
        elem_record_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind      = m_tuser;
            got.begin_idx = m_tdata[15:0];
            got.point_idx = m_tdata[30:16];
            got.end_idx   = m_tdata[45:31];
            got.last      = m_tlast;
            sb.check_record(got);
        end
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_sample(logic [15:0] y, bit up, bit nt);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= y;
        s_tuser  <= {nt, up};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_sample($signed(y), up, nt);
    endtask

    // hold the sender until every record is in and the core has settled
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_depth(int d);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= 15'(d);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_depth(d);
    endtask

    // a random-walk stroke followed by its pen-up beat
    task automatic send_stroke(int len, int step_max, bit fresh);
        int y;
        int dir;
        int k;
        y   = int'($urandom_range(65535)) - 32768;
        dir = 1;
        for (k = 0; k < len; k++)
        begin
            send_sample(16'(y), 1'b0, fresh && k == 0);
            if ($urandom_range(3) == 0)
                dir = -dir;
            y = y + dir * int'($urandom_range(step_max));
            if ($urandom_range(19) == 0)
                y = $urandom_range(1) ? 32767 : -32768;
            if (y > 32767)
                y = 32767;
            if (y < -32768)
                y = -32768;
        end
        send_sample(16'($urandom), 1'b1, 1'b0);
    endtask

    task automatic random_traffic(int count);
        int sent;
        int len;
        int step_max;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(15) == 0)
            begin
                send_sample(16'($urandom), 1'($urandom), $urandom_range(3) == 0);
                sent++;
            end
            else
            begin
                len      = $urandom_range(1, 30);
                step_max = $urandom_range(1, 3 * sb.depth + 8);
                if (step_max > 65535)
                    step_max = 65535;
                send_stroke(len, step_max, $urandom_range(11) == 0);
                sent += len + 1;
            end
        end
    endtask

    // short strokes, two records each, until the element table overflows
    task automatic fill_table();
        int k;
        send_sample(16'($urandom), 1'b1, 1'b1);
        for (k = 0; k < 130; k++)
        begin
            send_sample(16'($urandom), 1'b0, 1'b0);
            send_sample(16'($urandom), 1'b1, 1'b0);
        end
        send_stroke(20, 4000, 1'b0);
        send_stroke(12, 4000, 1'b1);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        tx_idle_pct = 23;
        rx_idle_pct = 65;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners at the reset depth
        send_sample(16'sd0, 1'b0, 1'b1);
        send_sample(16'sd32767, 1'b0, 1'b0);
        send_sample(16'h8000, 1'b0, 1'b0);
        send_sample(16'h8000, 1'b0, 1'b0);
        send_sample(16'h5a5a, 1'b1, 1'b0);      // pending min then stroke end
        send_sample(16'ha5a5, 1'b1, 1'b0);      // break after break
        send_sample(16'sd100, 1'b0, 1'b0);
        send_sample(16'sd110, 1'b0, 1'b0);
        send_sample(16'sd117, 1'b0, 1'b0);
        send_sample(16'sd116, 1'b0, 1'b0);
        send_sample(16'sd120, 1'b0, 1'b0);
        send_sample(16'sd50, 1'b1, 1'b0);
        send_sample(-16'sd5, 1'b0, 1'b0);
        send_sample(-16'sd30, 1'b0, 1'b0);
        send_sample(-16'sd20, 1'b0, 1'b0);
        send_sample(-16'sd40, 1'b0, 1'b1);      // new trace mid-stroke
        send_sample(-16'sd40, 1'b0, 1'b0);
        send_sample(16'hffff, 1'b1, 1'b1);      // new trace on a break
        send_sample(16'sd7, 1'b0, 1'b0);
        send_sample(16'sd7, 1'b1, 1'b0);
        drain();

        write_depth(2);
        random_traffic(100);
        drain();
        write_depth(1);
        fill_table();
        drain();
        write_depth(0);
        random_traffic(30);
        drain();

        tx_idle_pct = 65;
        rx_idle_pct = 23;
        write_depth(32767);
        random_traffic(80);
        drain();
        write_depth($urandom_range(200, 400));
        send_stroke(150, 40, 1'b1);             // long stroke, long searches
        random_traffic(50);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_depth($urandom_range(3, 64));
        random_traffic(70);
        drain();

        if (sb.errors == 0)
            $display("stroke_extremum_finder_core_tb passed");
        else
            $display("stroke_extremum_finder_core_tb failed");
        $finish;
    end

endmodule
